### sv/i2cm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master bit engine: command codes,
// bus phase encoding, wait length selection and the queued tick record.
// ---------------------------------------------------------------------------
package i2cm_pkg;

   // Command codes carried by each tick
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_PROBE = 2'd3;

   localparam int unsigned HalfPeriodWidth = 12;
   localparam int unsigned WaitWidth       = 18;
   localparam logic [HalfPeriodWidth-1:0] HalfPeriodReset = 12'd50;

   // Bus phases, one-hot
   typedef enum logic [24:0] {
      PH_IDLE = 25'h0000001,
      PH_ST1  = 25'h0000002,
      PH_ST2  = 25'h0000004,
      PH_AS   = 25'h0000008,
      PH_AH   = 25'h0000010,
      PH_AL   = 25'h0000020,
      PH_AKS  = 25'h0000040,
      PH_AKH1 = 25'h0000080,
      PH_AKH2 = 25'h0000100,
      PH_DS   = 25'h0000200,
      PH_DH   = 25'h0000400,
      PH_DL   = 25'h0000800,
      PH_DKS  = 25'h0001000,
      PH_DKH1 = 25'h0002000,
      PH_DKH2 = 25'h0004000,
      PH_RS   = 25'h0008000,
      PH_RH1  = 25'h0010000,
      PH_RH2  = 25'h0020000,
      PH_RL   = 25'h0040000,
      PH_NS   = 25'h0080000,
      PH_NH   = 25'h0100000,
      PH_NL   = 25'h0200000,
      PH_SP1  = 25'h0400000,
      PH_SP2  = 25'h0800000,
      PH_SP3  = 25'h1000000
   } phase_type;

   // Segment lengths in timing units
   typedef enum logic [1:0] {
      UNITS_1  = 2'd0,
      UNITS_2  = 2'd1,
      UNITS_5  = 2'd2,
      UNITS_40 = 2'd3
   } units_type;

   // One classified tick as it travels from front to back
   typedef struct packed {
      logic       start;       // op names a new command
      logic [1:0] kind;        // command code
      logic [7:0] shift_init;  // address and R/W bit
      logic [7:0] held;        // data byte for a write, else zero
      logic       line;        // sampled SDA level
   } item_type;

endpackage

### sv/i2cm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2cm_front
// Accept ticks, classify the command they carry and hold them in a
// two-entry queue for the bus sequencer.
// ---------------------------------------------------------------------------
module i2cm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [6:0]          req_address,
   input  logic [7:0]          req_write_data,
   input  logic                req_sda_in,
   input  logic                pop,
   output logic                item_valid,
   output i2cm_pkg::item_type  item
);

   i2cm_pkg::item_type entry_ff [2];
   i2cm_pkg::item_type classified;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   always_comb begin
      classified.start      = (req_op != i2cm_pkg::OP_TICK);
      classified.kind       = req_op;
      classified.shift_init = {req_address, (req_op == i2cm_pkg::OP_READ)};
      classified.held       = (req_op == i2cm_pkg::OP_WRITE) ? req_write_data : 8'd0;
      classified.line       = req_sda_in;
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/i2cm_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2cm_back
// Bus sequencer: advance the I2C phase machine by one queued tick per cycle
// unless stalled, and hold the line levels and status in an output register.
// ---------------------------------------------------------------------------
module i2cm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [11:0]         csr_wdata,
   input  logic                item_valid,
   input  i2cm_pkg::item_type  item,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_scl_out,
   output logic                rsp_sda_out,
   output logic                rsp_sda_drive,
   output logic                rsp_busy_res,
   output logic                rsp_done_res,
   output logic                rsp_addr_acked,
   output logic                rsp_data_acked,
   output logic [7:0]          rsp_read_data
);

   localparam int unsigned WW = i2cm_pkg::WaitWidth;

   logic [i2cm_pkg::HalfPeriodWidth-1:0] half_period_ff;
   i2cm_pkg::phase_type phase_ff, phase_in;
   logic [1:0]    kind_ff, kind_in;
   logic [3:0]    bit_idx_ff, bit_idx_in;
   logic [WW-1:0] wait_ff, wait_in;
   logic [7:0]    shift_ff, shift_in;
   logic [7:0]    held_ff, held_in;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in;
   logic          drv_ff, drv_in;
   logic [1:0]    ack_ff, ack_in;
   logic [7:0]    rxd_ff, rxd_in;
   logic          rsp_valid_ff;
   logic          done_ff, done_in;

   logic [WW-1:0] unit_len, len_2, len_5, len_40, wait_dec;
   logic          load_wait;
   i2cm_pkg::units_type units_sel;
   logic [3:0]    bit_next;

   assign pop = item_valid && (!rsp_valid_ff || !rsp_stall);

   // Segment lengths: zero half period counts as one
   always_comb begin
      unit_len = (half_period_ff == '0) ? WW'(1) : WW'(half_period_ff);
      len_2    = unit_len << 1;
      len_5    = (unit_len << 2) + unit_len;
      len_40   = (unit_len << 5) + (unit_len << 3);
      wait_dec = (wait_ff != '0) ? wait_ff - WW'(1) : '0;
      bit_next = bit_idx_ff + 4'd1;
   end

   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      bit_idx_in = bit_idx_ff;
      wait_in    = wait_ff;
      shift_in   = shift_ff;
      held_in    = held_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      drv_in     = drv_ff;
      ack_in     = ack_ff;
      rxd_in     = rxd_ff;
      done_in    = 1'b0;
      load_wait  = 1'b0;
      units_sel  = i2cm_pkg::UNITS_1;

      if (phase_ff == i2cm_pkg::PH_IDLE) begin
         if (item.start) begin
            kind_in    = item.kind;
            ack_in     = 2'b00;
            bit_idx_in = 4'd0;
            shift_in   = item.shift_init;
            held_in    = item.held;
            scl_in     = 1'b1;
            sda_in     = 1'b0;
            drv_in     = 1'b1;
            phase_in   = i2cm_pkg::PH_ST1;
            load_wait  = 1'b1;
         end
      end else begin
         wait_in = wait_dec;
         if (wait_dec == '0) begin
            load_wait = 1'b1;
            case (phase_ff)
               i2cm_pkg::PH_ST1: begin
                  scl_in   = 1'b0;
                  phase_in = i2cm_pkg::PH_ST2;
               end
               i2cm_pkg::PH_ST2: begin
                  bit_idx_in = 4'd0;
                  sda_in     = shift_ff[7];
                  drv_in     = 1'b1;
                  phase_in   = i2cm_pkg::PH_AS;
               end
               i2cm_pkg::PH_AS: begin
                  scl_in    = 1'b1;
                  phase_in  = i2cm_pkg::PH_AH;
                  units_sel = i2cm_pkg::UNITS_2;
               end
               i2cm_pkg::PH_AH: begin
                  scl_in   = 1'b0;
                  phase_in = i2cm_pkg::PH_AL;
               end
               i2cm_pkg::PH_AL: begin
                  bit_idx_in = bit_next;
                  if (bit_next < 4'd8) begin
                     sda_in   = shift_ff[~bit_next[2:0]];
                     drv_in   = 1'b1;
                     phase_in = i2cm_pkg::PH_AS;
                  end else begin
                     drv_in   = 1'b0;
                     phase_in = i2cm_pkg::PH_AKS;
                  end
               end
               i2cm_pkg::PH_AKS: begin
                  scl_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_AKH1;
               end
               i2cm_pkg::PH_AKH1: begin
                  if (!item.line) begin
                     ack_in[0] = 1'b1;
                  end
                  phase_in  = i2cm_pkg::PH_AKH2;
                  units_sel = i2cm_pkg::UNITS_5;
               end
               i2cm_pkg::PH_AKH2: begin
                  scl_in     = 1'b0;
                  bit_idx_in = 4'd0;
                  if (kind_ff == i2cm_pkg::OP_READ) begin
                     shift_in = 8'd0;
                     drv_in   = 1'b0;
                     phase_in = i2cm_pkg::PH_RS;
                  end else begin
                     shift_in = held_ff;
                     sda_in   = held_ff[7];
                     drv_in   = 1'b1;
                     phase_in = i2cm_pkg::PH_DS;
                  end
               end
               i2cm_pkg::PH_DS: begin
                  scl_in    = 1'b1;
                  phase_in  = i2cm_pkg::PH_DH;
                  units_sel = i2cm_pkg::UNITS_2;
               end
               i2cm_pkg::PH_DH: begin
                  scl_in   = 1'b0;
                  phase_in = i2cm_pkg::PH_DL;
               end
               i2cm_pkg::PH_DL: begin
                  bit_idx_in = bit_next;
                  if (bit_next < 4'd8) begin
                     sda_in   = shift_ff[~bit_next[2:0]];
                     drv_in   = 1'b1;
                     phase_in = i2cm_pkg::PH_DS;
                  end else if (kind_ff == i2cm_pkg::OP_WRITE) begin
                     drv_in   = 1'b0;
                     phase_in = i2cm_pkg::PH_DKS;
                  end else begin
                     sda_in   = 1'b0;
                     drv_in   = 1'b1;
                     phase_in = i2cm_pkg::PH_SP1;
                  end
               end
               i2cm_pkg::PH_DKS: begin
                  scl_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_DKH1;
               end
               i2cm_pkg::PH_DKH1: begin
                  if (!item.line) begin
                     ack_in[1] = 1'b1;
                  end
                  phase_in  = i2cm_pkg::PH_DKH2;
                  units_sel = i2cm_pkg::UNITS_5;
               end
               i2cm_pkg::PH_DKH2: begin
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
                  drv_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_SP1;
               end
               i2cm_pkg::PH_RS: begin
                  scl_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_RH1;
               end
               i2cm_pkg::PH_RH1: begin
                  shift_in = {shift_ff[6:0], item.line};
                  phase_in = i2cm_pkg::PH_RH2;
               end
               i2cm_pkg::PH_RH2: begin
                  scl_in   = 1'b0;
                  phase_in = i2cm_pkg::PH_RL;
               end
               i2cm_pkg::PH_RL: begin
                  bit_idx_in = bit_next;
                  if (bit_next < 4'd8) begin
                     phase_in = i2cm_pkg::PH_RS;
                  end else begin
                     rxd_in   = shift_ff;
                     sda_in   = 1'b1;
                     drv_in   = 1'b1;
                     phase_in = i2cm_pkg::PH_NS;
                  end
               end
               i2cm_pkg::PH_NS: begin
                  scl_in    = 1'b1;
                  phase_in  = i2cm_pkg::PH_NH;
                  units_sel = i2cm_pkg::UNITS_2;
               end
               i2cm_pkg::PH_NH: begin
                  scl_in   = 1'b0;
                  phase_in = i2cm_pkg::PH_NL;
               end
               i2cm_pkg::PH_NL: begin
                  sda_in   = 1'b0;
                  drv_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_SP1;
               end
               i2cm_pkg::PH_SP1: begin
                  scl_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_SP2;
               end
               i2cm_pkg::PH_SP2: begin
                  sda_in    = 1'b1;
                  phase_in  = i2cm_pkg::PH_SP3;
                  units_sel = i2cm_pkg::UNITS_40;
               end
               i2cm_pkg::PH_SP3: begin
                  phase_in  = i2cm_pkg::PH_IDLE;
                  load_wait = 1'b0;
                  wait_in   = '0;
                  done_in   = 1'b1;
               end
               default: begin
                  phase_in  = i2cm_pkg::PH_IDLE;
                  load_wait = 1'b0;
                  wait_in   = '0;
               end
            endcase
         end
      end

      if (load_wait) begin
         case (units_sel)
            i2cm_pkg::UNITS_1:  wait_in = unit_len;
            i2cm_pkg::UNITS_2:  wait_in = len_2;
            i2cm_pkg::UNITS_5:  wait_in = len_5;
            i2cm_pkg::UNITS_40: wait_in = len_40;
            default:            wait_in = unit_len;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= i2cm_pkg::HalfPeriodReset;
      end else if (csr_we) begin
         half_period_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cm_pkg::PH_IDLE;
         kind_ff      <= 2'd0;
         bit_idx_ff   <= 4'd0;
         wait_ff      <= '0;
         shift_ff     <= 8'd0;
         held_ff      <= 8'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         drv_ff       <= 1'b1;
         ack_ff       <= 2'b00;
         rxd_ff       <= 8'd0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff   <= phase_in;
            kind_ff    <= kind_in;
            bit_idx_ff <= bit_idx_in;
            wait_ff    <= wait_in;
            shift_ff   <= shift_in;
            held_ff    <= held_in;
            scl_ff     <= scl_in;
            sda_ff     <= sda_in;
            drv_ff     <= drv_in;
            ack_ff     <= ack_in;
            rxd_ff     <= rxd_in;
            done_ff    <= done_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The live state doubles as the result register
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_out    = scl_ff;
   assign rsp_sda_out    = sda_ff;
   assign rsp_sda_drive  = drv_ff;
   assign rsp_busy_res   = (phase_ff != i2cm_pkg::PH_IDLE);
   assign rsp_done_res   = done_ff;
   assign rsp_addr_acked = ack_ff[0];
   assign rsp_data_acked = ack_ff[1];
   assign rsp_read_data  = rxd_ff;

endmodule

### sv/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_master_bit_engine
// Single-master I2C engine driven by timing ticks.
// ---------------------------------------------------------------------------
// Every request transaction is one timing tick and yields exactly one
// response transaction carrying the SCL/SDA levels to drive, the busy and
// done flags, both ACK flags and the last received byte. A tick with a
// non-zero op starts a write, read or probe when the engine is idle and is
// otherwise treated as a plain tick. Bus timing counts ticks in units of
// half_period (written through csr_we/csr_wdata, reset 50, zero acts as 1);
// write it only while the engine is idle. One tick is taken per clock:
// a two-entry queue decouples the request side from the phase sequencer,
// and the sequencer's state register is also the response register, so a
// tick enters and a response leaves in every cycle while rsp_stall is low.
// An accepted tick passes the queue register and then the sequencer
// register before its response appears.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [11:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [6:0]  req_address,
   input  logic [7:0]  req_write_data,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_sda_drive,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_addr_acked,
   output logic        rsp_data_acked,
   output logic [7:0]  rsp_read_data
);

   // Queue to sequencer hand-over
   i2cm_pkg::item_type item;
   logic               item_valid;
   logic               pop;

   // Front: classify each tick and queue it
   i2cm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_sda_in     (req_sda_in),
      .pop            (pop),
      .item_valid     (item_valid),
      .item           (item)
   );

   // Back: advance the bus phases, one queued tick per cycle while rsp_stall is low
   i2cm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .item_valid     (item_valid),
      .item           (item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl_out    (rsp_scl_out),
      .rsp_sda_out    (rsp_sda_out),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_addr_acked (rsp_addr_acked),
      .rsp_data_acked (rsp_data_acked),
      .rsp_read_data  (rsp_read_data)
   );

endmodule

### sv/i2cm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master bit engine, bound to the top level.
// ---------------------------------------------------------------------------
module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_scl_out,
   input logic       rsp_sda_out,
   input logic       rsp_sda_drive,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_read_data
);

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_busy_res) && $stable(rsp_scl_out))
      else $error("stalled response changed");

   // A finishing transaction leaves the engine idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while busy");

   // An idle bus has both lines driven high
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_scl_out && rsp_sda_out && rsp_sda_drive)
      else $error("idle bus not released high");

   // Release SDA only inside a transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sda_drive |-> rsp_busy_res)
      else $error("SDA released while idle");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_scl_out   (rsp_scl_out),
   .rsp_sda_out   (rsp_sda_out),
   .rsp_sda_drive (rsp_sda_drive),
   .rsp_busy_res  (rsp_busy_res),
   .rsp_done_res  (rsp_done_res),
   .rsp_read_data (rsp_read_data)
);
